### rtl/core/fpgd_pkg.sv
package fpgd_pkg;

    localparam int DATA_BITS = 64;
    localparam int CNT_BITS  = 3;

    localparam logic OP_DIVIDE = 1'b0;
    localparam logic OP_RECIP  = 1'b1;

    localparam logic [CNT_BITS:0] DEFAULT_ITERS = 4'd2;

    localparam logic [63:0] GUESS_NUM = 64'd29142;
    localparam logic [63:0] GUESS_DEN = 64'd10000;

    typedef struct packed {
        logic                        operation;
        logic signed [DATA_BITS-1:0] dividend;
        logic signed [DATA_BITS-1:0] divisor;
    } t_in;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] quotient;
        logic                        divisor_zero;
    } t_out;

endpackage

### rtl/core/fixed_point_goldschmidt_divider.sv
// Fixed-point Goldschmidt divider and reciprocal unit.
// Input channel: i_in_valid / o_in_stall carry one beat of operation, dividend
// and divisor; a beat is taken at a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry one beat of quotient and
// divisor_zero for every input beat, in order.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the iteration count
// (zero means two); write it only while no beat is in flight.
// Pipeline depth is set by the unrolled iteration stages, each of which needs
// an operand add, a partial-product stage and a summing stage.
// Throughput: one beat per cycle while o_in_stall is low; every 64-bit product
// is split into three half-width partial products, so no stage holds more
// than one multiply level.
// Receiver stall: an output register plus one skid entry absorb the beat in
// flight; o_in_stall rises only when the skid entry is full, and the whole
// pipeline then holds until the output drains.
// Reset: synchronous, active low; clears all valid bits, the skid entry and
// the iteration count.
module fixed_point_goldschmidt_divider #(
    parameter int WORD_BITS      = 64,
    parameter int FRAC_BITS      = 18,
    parameter int MAX_ITERATIONS = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [fpgd_pkg::CNT_BITS-1:0]   i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fpgd_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fpgd_pkg::t_out                  o_out_data
);
    import fpgd_pkg::*;

    localparam int HB   = WORD_BITS / 2;
    localparam int UB   = WORD_BITS - HB;
    localparam int SB   = $clog2(WORD_BITS);
    localparam int JMAX = (2 * FRAC_BITS > WORD_BITS) ? 2 * FRAC_BITS - 1 : WORD_BITS - 1;
    localparam int JB   = $clog2(JMAX + 1);
    localparam int NCH  = (WORD_BITS + 7) / 8;

    localparam logic [WORD_BITS-1:0] FX_ONE   = WORD_BITS'(64'd1 << FRAC_BITS);
    localparam logic [WORD_BITS-1:0] FX_GUESS =
        WORD_BITS'((GUESS_NUM << FRAC_BITS) / GUESS_DEN);

    typedef struct packed {
        logic          op;
        logic          neg;
        logic          bz;
        logic          fz;
        logic [JB-1:0] j;
        logic [WORD_BITS-1:0] a;
    } t_ctx;

    typedef struct packed {
        logic [2*HB-1:0] ll;
        logic [UB-1:0]   c1;
        logic [UB-1:0]   c2;
    } t_pp;

    function automatic t_pp mul_pp(input logic [WORD_BITS-1:0] x,
                                   input logic [WORD_BITS-1:0] y);
        t_pp           pp;
        logic [UB-1:0] t1;
        logic [UB-1:0] t2;
        pp.ll = x[HB-1:0] * y[HB-1:0];
        t1 = x[WORD_BITS-1:HB] * y[HB-1:0];
        t2 = x[HB-1:0] * y[WORD_BITS-1:HB];
        pp.c1 = t1;
        pp.c2 = t2;
        return pp;
    endfunction

    function automatic logic [WORD_BITS-1:0] mul_sum(input t_pp pp);
        logic [UB-1:0]        cs;
        logic [WORD_BITS-1:0] p;
        cs = pp.c1 + pp.c2;
        p = WORD_BITS'(pp.ll) + {cs, {HB{1'b0}}};
        return WORD_BITS'($signed(p) >>> FRAC_BITS);
    endfunction

    function automatic logic [WORD_BITS-1:0] fx_scale(input logic [WORD_BITS-1:0] x,
                                                      input logic [SB-1:0] sh,
                                                      input logic zero);
        logic [WORD_BITS-1:0] p;
        p = x << sh;
        return zero ? '0 : WORD_BITS'($signed(p) >>> FRAC_BITS);
    endfunction

    logic en;

    logic r_skid_v;
    logic r_out_v;
    t_out r_skid_data;
    t_out r_out_data;

    logic [CNT_BITS-1:0] r_iteration_count;
    logic [CNT_BITS:0]   iters;

    assign en         = !r_skid_v;
    assign o_in_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iteration_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_iteration_count <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if (r_iteration_count == '0) begin
            iters = DEFAULT_ITERS;
        end else if ({1'b0, r_iteration_count} > (CNT_BITS+1)'(MAX_ITERATIONS)) begin
            iters = (CNT_BITS+1)'(MAX_ITERATIONS);
        end else begin
            iters = {1'b0, r_iteration_count};
        end
    end

    // front end: sign, magnitude, leading one, scale factor, initial guess
    logic [WORD_BITS-1:0] in_b;
    logic                 in_neg;

    assign in_b   = i_in_data.divisor[WORD_BITS-1:0];
    assign in_neg = in_b[WORD_BITS-1];

    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v, r_s7_v, r_s8_v, r_s9_v;
    t_ctx r_s1_ctx, r_s2_ctx, r_s3_ctx, r_s4_ctx, r_s5_ctx, r_s6_ctx, r_s7_ctx;
    t_ctx r_s8_ctx, r_s9_ctx;
    logic [WORD_BITS-1:0] r_s1_mag, r_s2_mag, r_s3_mag, r_s4_mag, r_s5_mag;
    logic [WORD_BITS-1:0] r_s4_c, r_s5_c, r_s5_w;
    logic [WORD_BITS-1:0] r_s6_r, r_s6_x, r_s7_r, r_s8_r, r_s8_p, r_s9_r, r_s9_e;
    t_pp                  r_s7_pp;
    logic                 r_s2_any [NCH];
    logic [2:0]           r_s2_pos [NCH];

    logic                 n_s2_any [NCH];
    logic [2:0]           n_s2_pos [NCH];
    logic [NCH*8-1:0]     mag_pad;
    logic [JB-1:0]        top;
    logic                 found;
    logic [JB-1:0]        n_s3_j;
    logic                 n_s3_fz;
    t_ctx                 n_s3_ctx;

    always_comb begin
        mag_pad = (NCH*8)'(r_s1_mag);
        for (int ch = 0; ch < NCH; ch++) begin
            n_s2_any[ch] = |mag_pad[ch*8 +: 8];
            n_s2_pos[ch] = '0;
            for (int b = 0; b < 8; b++) begin
                if (mag_pad[ch*8 + b]) begin
                    n_s2_pos[ch] = 3'(b);
                end
            end
        end
    end

    always_comb begin
        top   = '0;
        found = 1'b0;
        for (int ch = 0; ch < NCH; ch++) begin
            if (r_s2_any[ch]) begin
                top   = JB'(ch * 8) + JB'(r_s2_pos[ch]);
                found = 1'b1;
            end
        end
        n_s3_j  = (top <= JB'(2 * FRAC_BITS - 1)) ? JB'(2 * FRAC_BITS - 1) - top : top;
        n_s3_fz = !found || ({1'b0, n_s3_j} >= (JB+1)'(WORD_BITS));
        n_s3_ctx    = r_s2_ctx;
        n_s3_ctx.j  = n_s3_j;
        n_s3_ctx.fz = n_s3_fz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
            r_s8_v <= 1'b0;
            r_s9_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_in_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_s7_v <= r_s6_v;
            r_s8_v <= r_s7_v;
            r_s9_v <= r_s8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ctx.op  <= i_in_data.operation;
            r_s1_ctx.neg <= in_neg;
            r_s1_ctx.bz  <= (in_b == '0);
            r_s1_ctx.fz  <= 1'b0;
            r_s1_ctx.j   <= '0;
            r_s1_ctx.a   <= i_in_data.dividend[WORD_BITS-1:0];
            r_s1_mag     <= in_neg ? -in_b : in_b;

            r_s2_ctx <= r_s1_ctx;
            r_s2_mag <= r_s1_mag;
            r_s2_any <= n_s2_any;
            r_s2_pos <= n_s2_pos;

            r_s3_ctx <= n_s3_ctx;
            r_s3_mag <= r_s2_mag;

            r_s4_ctx <= r_s3_ctx;
            r_s4_mag <= r_s3_mag;
            r_s4_c   <= fx_scale(r_s3_mag, r_s3_ctx.j[SB-1:0], r_s3_ctx.fz);

            r_s5_ctx <= r_s4_ctx;
            r_s5_mag <= r_s4_mag;
            r_s5_c   <= r_s4_c;
            r_s5_w   <= FX_GUESS - {r_s4_c[WORD_BITS-2:0], 1'b0};

            r_s6_ctx <= r_s5_ctx;
            r_s6_r   <= (r_s5_ctx.op == OP_RECIP)
                        ? fx_scale(r_s5_w, r_s5_ctx.j[SB-1:0], r_s5_ctx.fz) : r_s5_w;
            r_s6_x   <= (r_s5_ctx.op == OP_RECIP) ? r_s5_mag : r_s5_c;

            r_s7_ctx <= r_s6_ctx;
            r_s7_r   <= r_s6_r;
            r_s7_pp  <= mul_pp(r_s6_x, r_s6_r);

            r_s8_ctx <= r_s7_ctx;
            r_s8_r   <= r_s7_r;
            r_s8_p   <= mul_sum(r_s7_pp);

            r_s9_ctx <= r_s8_ctx;
            r_s9_r   <= r_s8_r;
            r_s9_e   <= FX_ONE - r_s8_p;
        end
    end

    // unrolled Goldschmidt iterations
    logic                 chain_v   [MAX_ITERATIONS+1];
    t_ctx                 chain_ctx [MAX_ITERATIONS+1];
    logic [WORD_BITS-1:0] chain_r   [MAX_ITERATIONS+1];
    logic [WORD_BITS-1:0] chain_e   [MAX_ITERATIONS+1];

    assign chain_v[0]   = r_s9_v;
    assign chain_ctx[0] = r_s9_ctx;
    assign chain_r[0]   = r_s9_r;
    assign chain_e[0]   = r_s9_e;

    for (genvar k = 0; k < MAX_ITERATIONS; k++) begin : g_iter
        logic                 r_ka_v, r_kb_v, r_kc_v;
        t_ctx                 r_ka_ctx, r_kb_ctx, r_kc_ctx;
        logic [WORD_BITS-1:0] r_ka_r, r_ka_e, r_ka_ep1;
        logic [WORD_BITS-1:0] r_kb_r, r_kb_e, r_kc_r, r_kc_e;
        t_pp                  r_kb_pr, r_kb_pe;
        logic                 act;

        assign act = ((CNT_BITS+1)'(k) < iters);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ka_v <= 1'b0;
                r_kb_v <= 1'b0;
                r_kc_v <= 1'b0;
            end else if (en) begin
                r_ka_v <= chain_v[k];
                r_kb_v <= r_ka_v;
                r_kc_v <= r_kb_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ka_ctx <= chain_ctx[k];
                r_ka_r   <= chain_r[k];
                r_ka_e   <= chain_e[k];
                r_ka_ep1 <= chain_e[k] + FX_ONE;

                r_kb_ctx <= r_ka_ctx;
                r_kb_r   <= r_ka_r;
                r_kb_e   <= r_ka_e;
                r_kb_pr  <= mul_pp(r_ka_r, r_ka_ep1);
                r_kb_pe  <= mul_pp(r_ka_e, r_ka_e);

                r_kc_ctx <= r_kb_ctx;
                r_kc_r   <= act ? mul_sum(r_kb_pr) : r_kb_r;
                r_kc_e   <= act ? mul_sum(r_kb_pe) : r_kb_e;
            end
        end

        assign chain_v[k+1]   = r_kc_v;
        assign chain_ctx[k+1] = r_kc_ctx;
        assign chain_r[k+1]   = r_kc_r;
        assign chain_e[k+1]   = r_kc_e;
    end

    // back end: dividend product, scale, sign
    logic                 r_f1_v, r_f2_v, r_f3_v, r_f4_v;
    t_ctx                 r_f1_ctx, r_f2_ctx, r_f3_ctx, r_f4_ctx;
    t_pp                  r_f1_pp;
    logic [WORD_BITS-1:0] r_f1_r, r_f2_r, r_f2_p, r_f3_q, r_f4_q;
    t_out                 n_f4_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
            r_f4_v <= 1'b0;
        end else if (en) begin
            r_f1_v <= chain_v[MAX_ITERATIONS];
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
            r_f4_v <= r_f3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_ctx <= chain_ctx[MAX_ITERATIONS];
            r_f1_r   <= chain_r[MAX_ITERATIONS];
            r_f1_pp  <= mul_pp(chain_r[MAX_ITERATIONS], chain_ctx[MAX_ITERATIONS].a);

            r_f2_ctx <= r_f1_ctx;
            r_f2_r   <= r_f1_r;
            r_f2_p   <= mul_sum(r_f1_pp);

            r_f3_ctx <= r_f2_ctx;
            r_f3_q   <= (r_f2_ctx.op == OP_RECIP)
                        ? r_f2_r : fx_scale(r_f2_p, r_f2_ctx.j[SB-1:0], r_f2_ctx.fz);

            r_f4_ctx <= r_f3_ctx;
            r_f4_q   <= r_f3_ctx.neg ? -r_f3_q : r_f3_q;
        end
    end

    always_comb begin
        n_f4_out.quotient     = DATA_BITS'($signed(r_f4_q));
        n_f4_out.divisor_zero = r_f4_ctx.bz;
    end

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_out_stall) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r_f4_v;
            end
        end else if (r_f4_v && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_out_stall) begin
            if (r_skid_v) begin
                r_out_data <= r_skid_data;
            end else begin
                r_out_data <= n_f4_out;
            end
        end else if (!r_skid_v) begin
            r_skid_data <= n_f4_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out_data;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry full while output register empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_out_stall && r_f4_v))
        else $error("skid entry filled without a held output beat");

    a_zero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.divisor_zero) |-> (o_out_data.quotient == '0))
        else $error("zero divisor produced a nonzero quotient");

endmodule

### verif/fixed_point_goldschmidt_divider_checker.sv
module fixed_point_goldschmidt_divider_checker #(
    parameter int FRAC_BITS      = 18,
    parameter int MAX_ITERATIONS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [fpgd_pkg::CNT_BITS-1:0] i_cfg_wr_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  fpgd_pkg::t_in                 i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  fpgd_pkg::t_out                i_out_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int SCALE_BITS = 2 * FRAC_BITS;
    localparam logic [63:0] FX_ONE = 64'd1 << FRAC_BITS;
    localparam logic [63:0] FX_GUESS = (fpgd_pkg::GUESS_NUM << FRAC_BITS) / fpgd_pkg::GUESS_DEN;

    logic [fpgd_pkg::CNT_BITS-1:0] iter_count = '0;
    fpgd_pkg::t_out                quotient_q[$];
    int                            fails = 0;
    int                            result_index = 0;

    function automatic logic [63:0] fx_mul(input logic [63:0] x, input logic [63:0] y);
        logic signed [63:0] prod;
        prod = x * y;
        return prod >>> FRAC_BITS;
    endfunction

    function automatic logic [63:0] leading_one(input logic [63:0] x);
        logic [63:0] bit_mask;
        bit_mask = '0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                bit_mask = 64'd1 << i;
            end
        end
        return bit_mask;
    endfunction

    function automatic logic [63:0] scale_factor(input logic [63:0] x);
        logic [63:0] fac;
        fac = x;
        for (int i = 0; i < SCALE_BITS; i++) begin
            fac[SCALE_BITS-1-i] = x[i];
        end
        return fac;
    endfunction

    function automatic fpgd_pkg::t_out predict_quotient(input fpgd_pkg::t_in beat,
                                                        input logic [fpgd_pkg::CNT_BITS-1:0] cnt);
        fpgd_pkg::t_out res;
        logic           neg;
        logic [63:0]    num;
        logic [63:0]    den;
        logic [63:0]    mag;
        logic [63:0]    fac;
        logic [63:0]    norm;
        logic [63:0]    guess;
        logic [63:0]    r;
        logic [63:0]    e;
        int             iters;
        num   = beat.dividend;
        den   = beat.divisor;
        neg   = den[63];
        mag   = neg ? (64'd0 - den) : den;
        fac   = scale_factor(leading_one(mag));
        norm  = fx_mul(mag, fac);
        guess = FX_GUESS - (norm << 1);
        if (cnt == 0) begin
            iters = int'(fpgd_pkg::DEFAULT_ITERS);
        end else if (int'(cnt) > MAX_ITERATIONS) begin
            iters = MAX_ITERATIONS;
        end else begin
            iters = int'(cnt);
        end
        if (beat.operation == fpgd_pkg::OP_RECIP) begin
            r = fx_mul(guess, fac);
            e = FX_ONE - fx_mul(mag, r);
        end else begin
            r = guess;
            e = FX_ONE - fx_mul(norm, guess);
        end
        for (int k = 0; k < iters; k++) begin
            r = fx_mul(r, e + FX_ONE);
            e = fx_mul(e, e);
        end
        if (beat.operation == fpgd_pkg::OP_DIVIDE) begin
            r = fx_mul(fx_mul(r, num), fac);
        end
        res.quotient     = neg ? (64'd0 - r) : r;
        res.divisor_zero = (den == 64'd0);
        return res;
    endfunction

    always @(posedge i_clk) begin
        fpgd_pkg::t_out want;
        if (!i_rst_n) begin
            iter_count <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                iter_count <= i_cfg_wr_data;
            end
            if (i_in_valid && !i_in_stall) begin
                quotient_q.push_back(predict_quotient(i_in_data, iter_count));
            end
            if (i_out_valid && !i_out_stall) begin
                if (quotient_q.size() == 0) begin
                    if (fails < 10) begin
                        $display("unexpected beat %0d: quotient %h divisor_zero %b",
                                 result_index, i_out_data.quotient, i_out_data.divisor_zero);
                    end
                    fails++;
                end else begin
                    want = quotient_q.pop_front();
                    if (i_out_data.quotient !== want.quotient) begin
                        if (fails < 10) begin
                            $display("beat %0d quotient: expected %h actual %h",
                                     result_index, want.quotient, i_out_data.quotient);
                        end
                        fails++;
                    end
                    if (i_out_data.divisor_zero !== want.divisor_zero) begin
                        if (fails < 10) begin
                            $display("beat %0d divisor_zero: expected %b actual %b",
                                     result_index, want.divisor_zero, i_out_data.divisor_zero);
                        end
                        fails++;
                    end
                end
                result_index++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= quotient_q.size();
    end

endmodule

### verif/fixed_point_goldschmidt_divider_tb.sv
module fixed_point_goldschmidt_divider_tb;

    import fpgd_pkg::*;

    localparam int FRAC_BITS      = 18;
    localparam int MAX_ITERATIONS = 6;
    localparam int LATENCY        = 13 + 3 * MAX_ITERATIONS;
    localparam int QUIET_LIMIT    = 2000;
    localparam int PHASE_ITEMS    = 188;

    localparam logic [63:0] FX_ONE   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_POS  = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] SCALE_TOP = 64'd1 << (2 * FRAC_BITS);

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CNT_BITS-1:0] cfg_wr_data = '0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    t_in                 in_data     = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    t_out                out_data;
    int                  fail_count;
    int                  pending;
    int                  snd_idle    = 0;
    int                  rcv_idle    = 0;

    fixed_point_goldschmidt_divider #(
        .WORD_BITS      (64),
        .FRAC_BITS      (FRAC_BITS),
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (out_data)
    );

    fixed_point_goldschmidt_divider_checker #(
        .FRAC_BITS      (FRAC_BITS),
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) quotient_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < rcv_idle);
    end

    function automatic t_in make_beat(input logic op, input logic [63:0] num,
                                      input logic [63:0] den);
        t_in beat;
        beat.operation = op;
        beat.dividend  = num;
        beat.divisor   = den;
        return beat;
    endfunction

    function automatic logic [63:0] rand_word(input int bits);
        logic [63:0] w;
        w = {$urandom, $urandom};
        if (bits < 64) begin
            w = w & ((64'd1 << bits) - 64'd1);
        end
        return w;
    endfunction

    function automatic logic [63:0] rand_divisor();
        logic [63:0] mag;
        int          sel;
        sel = $urandom_range(99);
        if (sel < 50) begin
            mag = rand_word($urandom_range(1, 2 * FRAC_BITS));
        end else if (sel < 65) begin
            mag = rand_word($urandom_range(FRAC_BITS - 4, FRAC_BITS + 4));
        end else if (sel < 80) begin
            return rand_word(64);
        end else if (sel < 85) begin
            return 64'd0;
        end else begin
            case ($urandom_range(6))
                0: mag = MOST_NEG;
                1: mag = 64'd1;
                2: mag = ALL_ONES;
                3: mag = SCALE_TOP;
                4: mag = SCALE_TOP - 64'd1;
                5: mag = MAX_POS;
                default: mag = FX_ONE;
            endcase
        end
        return $urandom_range(1) ? (64'd0 - mag) : mag;
    endfunction

    function automatic logic [63:0] rand_dividend();
        logic [63:0] num;
        int          sel;
        sel = $urandom_range(99);
        if (sel < 60) begin
            num = rand_word($urandom_range(1, 40));
            return $urandom_range(1) ? (64'd0 - num) : num;
        end else if (sel < 90) begin
            return rand_word(64);
        end
        case ($urandom_range(3))
            0: num = 64'd0;
            1: num = MOST_NEG;
            2: num = MAX_POS;
            default: num = ALL_ONES;
        endcase
        return num;
    endfunction

    task automatic send_beat(input t_in beat);
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_iter_count(input logic [CNT_BITS-1:0] cnt);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cnt;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int phase_counts[8];
        phase_counts = '{1, 6, 7, 3, 0, 4, 2, 5};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        snd_idle = 21;
        rcv_idle = 57;
        send_beat(make_beat(OP_DIVIDE, FX_ONE, FX_ONE));
        send_beat(make_beat(OP_RECIP, 64'd0, FX_ONE));
        send_beat(make_beat(OP_DIVIDE, FX_ONE, 64'd0));
        send_beat(make_beat(OP_RECIP, ALL_ONES, 64'd0));
        send_beat(make_beat(OP_DIVIDE, FX_ONE, MOST_NEG));
        send_beat(make_beat(OP_RECIP, 64'd0, MOST_NEG));
        send_beat(make_beat(OP_DIVIDE, MAX_POS, 64'd1));
        send_beat(make_beat(OP_DIVIDE, MOST_NEG, ALL_ONES));
        send_beat(make_beat(OP_RECIP, 64'd0, 64'd1));
        send_beat(make_beat(OP_RECIP, 64'd0, ALL_ONES));
        send_beat(make_beat(OP_DIVIDE, 64'd0 - 3 * FX_ONE, 2 * FX_ONE));
        send_beat(make_beat(OP_RECIP, 64'd0, SCALE_TOP - 64'd1));
        send_beat(make_beat(OP_DIVIDE, FX_ONE, SCALE_TOP));
        send_beat(make_beat(OP_RECIP, 64'd0, MAX_POS));
        send_beat(make_beat(OP_DIVIDE, ALL_ONES, 3 * FX_ONE));
        send_beat(make_beat(OP_RECIP, 64'd0, FX_ONE >> 1));
        send_beat(make_beat(OP_DIVIDE, 7 * FX_ONE, FX_ONE + 64'd1));
        send_beat(make_beat(OP_DIVIDE, 64'd0 - FX_ONE, 64'd0 - FX_ONE));
        send_beat(make_beat(OP_RECIP, 64'd0, 64'd0 - 5 * FX_ONE));
        send_beat(make_beat(OP_DIVIDE, MOST_NEG, MAX_POS));
        wait_results_drained();

        for (int p = 0; p < 8; p++) begin
            if (p < 2) begin
                snd_idle = 21;
                rcv_idle = 57;
            end else if (p < 5) begin
                snd_idle = 57;
                rcv_idle = 21;
            end else begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            write_iter_count(phase_counts[p][CNT_BITS-1:0]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_beat(make_beat(1'($urandom_range(1)), rand_dividend(), rand_divisor()));
            end
            wait_results_drained();
        end

        repeat (LATENCY + 16) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
